// ----- sv/escd_pkg.sv -----
// escd_pkg: types and constants shared by the escape sequence decoder
// depends on nothing
package escd_pkg;

   typedef enum logic [1:0] {
      MODE_TEXT   = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_DIGITS = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_OCTAL = 2'd0,
      KIND_HEX   = 2'd1,
      KIND_SHORT = 2'd2,
      KIND_LONG  = 2'd3
   } kind_type;

   localparam logic [2:0] StatusByte     = 3'd0;
   localparam logic [2:0] StatusDone     = 3'd1;
   localparam logic [2:0] StatusTrunc    = 3'd2;
   localparam logic [2:0] StatusBadDigit = 3'd3;
   localparam logic [2:0] StatusBadCp    = 3'd4;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } utf8_type;

   // one queue entry: up to four bytes, then an optional status result
   typedef struct packed {
      utf8_type   data;
      logic       tail;
      logic [2:0] tail_status;
   } work_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.count    = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.count    = 3'd2;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.count    = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.count    = 3'd4;
      end
      return r;
   endfunction

endpackage

// ----- sv/escd_front.sv -----
// escd_front: parser state, escape classification and utf-8 encoding
// depends on escd_pkg
module escd_front import escd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [20:0] code_point,
   input  logic        end_of_string,
   output logic        work_push,
   output work_type    work
);

   localparam logic [20:0] ChBackslash  = 21'h5c;
   localparam logic [20:0] ChSQuote     = 21'h27;
   localparam logic [20:0] ChDQuote     = 21'h22;
   localparam logic [20:0] ChUnderscore = 21'h5f;
   localparam logic [20:0] ChLowA       = 21'h61;
   localparam logic [20:0] ChLowB       = 21'h62;
   localparam logic [20:0] ChLowE       = 21'h65;
   localparam logic [20:0] ChLowN       = 21'h6e;
   localparam logic [20:0] ChLowR       = 21'h72;
   localparam logic [20:0] ChLowT       = 21'h74;
   localparam logic [20:0] ChLowV       = 21'h76;
   localparam logic [20:0] ChLowX       = 21'h78;
   localparam logic [20:0] ChLowU       = 21'h75;
   localparam logic [20:0] ChUpU        = 21'h55;

   mode_type    mode_ff, mode_in;
   kind_type    kind_ff, kind_in;
   logic [3:0]  left_ff, left_in;
   logic [31:0] acc_ff, acc_in;
   logic        err_seen_ff, err_seen_in;

   logic        digit_ok;
   logic [3:0]  digit_val;
   logic        err;
   logic [2:0]  err_status;
   utf8_type    enc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TEXT;
         kind_ff     <= KIND_OCTAL;
         left_ff     <= '0;
         acc_ff      <= '0;
         err_seen_ff <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         kind_ff     <= kind_in;
         left_ff     <= left_in;
         acc_ff      <= acc_in;
         err_seen_ff <= err_seen_in;
      end
   end

   // digit decode for the current escape kind
   always_comb begin
      digit_ok  = 1'b0;
      digit_val = code_point[3:0];
      if (kind_ff == KIND_OCTAL) begin
         digit_ok = (code_point >= 21'h30) && (code_point <= 21'h37);
      end else if ((code_point >= 21'h30) && (code_point <= 21'h39)) begin
         digit_ok = 1'b1;
      end else if (((code_point >= 21'h61) && (code_point <= 21'h66)) ||
                   ((code_point >= 21'h41) && (code_point <= 21'h46))) begin
         digit_ok  = 1'b1;
         digit_val = code_point[3:0] + 4'd9;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      kind_in     = kind_ff;
      left_in     = left_ff;
      acc_in      = acc_ff;
      err_seen_in = err_seen_ff;
      err         = 1'b0;
      err_status  = StatusBadDigit;
      enc         = '0;
      work        = '0;
      work_push   = 1'b0;

      if (err_seen_ff) begin
         if (end_of_string) begin
            mode_in     = MODE_TEXT;
            kind_in     = KIND_OCTAL;
            left_in     = '0;
            acc_in      = '0;
            err_seen_in = 1'b0;
         end
      end else begin
         unique case (mode_ff)
            MODE_TEXT: begin
               if (code_point == ChBackslash) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  enc = utf8_encode(code_point);
               end
            end
            MODE_ESCAPE: begin
               mode_in = MODE_TEXT;
               unique case (code_point)
                  ChLowA:      begin enc.bytes[0] = 8'h07; enc.count = 3'd1; end
                  ChLowB:      begin enc.bytes[0] = 8'h08; enc.count = 3'd1; end
                  ChLowE:      begin enc.bytes[0] = 8'h1b; enc.count = 3'd1; end
                  ChLowN:      begin enc.bytes[0] = 8'h0a; enc.count = 3'd1; end
                  ChLowR:      begin enc.bytes[0] = 8'h0d; enc.count = 3'd1; end
                  ChLowT:      begin enc.bytes[0] = 8'h09; enc.count = 3'd1; end
                  ChLowV:      begin enc.bytes[0] = 8'h0b; enc.count = 3'd1; end
                  ChBackslash, ChSQuote, ChDQuote: begin
                     enc.bytes[0] = code_point[7:0];
                     enc.count    = 3'd1;
                  end
                  ChLowX: begin
                     mode_in = MODE_DIGITS;
                     kind_in = KIND_HEX;
                     left_in = 4'd2;
                     acc_in  = '0;
                  end
                  ChLowU: begin
                     mode_in = MODE_DIGITS;
                     kind_in = KIND_SHORT;
                     left_in = 4'd4;
                     acc_in  = '0;
                  end
                  ChUpU: begin
                     mode_in = MODE_DIGITS;
                     kind_in = KIND_LONG;
                     left_in = 4'd8;
                     acc_in  = '0;
                  end
                  default: begin
                     if ((code_point >= 21'h30) && (code_point <= 21'h37)) begin
                        mode_in = MODE_DIGITS;
                        kind_in = KIND_OCTAL;
                        left_in = 4'd2;
                        acc_in  = {29'd0, code_point[2:0]};
                     end else begin
                        err = 1'b1;
                     end
                  end
               endcase
            end
            MODE_DIGITS: begin
               if (code_point != ChUnderscore) begin
                  if (!digit_ok) begin
                     err = 1'b1;
                  end else begin
                     if (kind_ff == KIND_OCTAL) begin
                        acc_in = {acc_ff[28:0], digit_val[2:0]};
                     end else begin
                        acc_in = {acc_ff[27:0], digit_val};
                     end
                     left_in = left_ff - 4'd1;
                     if (left_in == 4'd0) begin
                        mode_in = MODE_TEXT;
                        if ((kind_ff == KIND_OCTAL) || (kind_ff == KIND_HEX)) begin
                           enc.bytes[0] = acc_in[7:0];
                           enc.count    = 3'd1;
                        end else if ((acc_in < 32'h110000) &&
                                     ((acc_in < 32'hd800) || (acc_in > 32'hdfff))) begin
                           enc = utf8_encode(acc_in[20:0]);
                        end else begin
                           err        = 1'b1;
                           err_status = StatusBadCp;
                        end
                        acc_in = '0;
                     end
                  end
               end
            end
            default: begin
               mode_in = MODE_TEXT;
            end
         endcase

         work.data = enc;
         if (err) begin
            work.data        = '0;
            work.tail        = 1'b1;
            work.tail_status = err_status;
         end else if (end_of_string) begin
            work.tail        = 1'b1;
            work.tail_status = (mode_in != MODE_TEXT) ? StatusTrunc : StatusDone;
         end

         if (err && !end_of_string) begin
            err_seen_in = 1'b1;
         end else if (end_of_string) begin
            mode_in     = MODE_TEXT;
            kind_in     = KIND_OCTAL;
            left_in     = '0;
            acc_in      = '0;
            err_seen_in = 1'b0;
         end

         work_push = accept && (work.tail || (work.data.count != 3'd0));
      end
   end

endmodule

// ----- sv/escd_fifo.sv -----
// escd_fifo: short register queue of work entries between front and back
// depends on escd_pkg
module escd_fifo import escd_pkg::*; #(
   parameter int Depth = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  work_type wr_data,
   input  logic     rd_en,
   output work_type rd_data,
   output logic     q_full,
   output logic     q_empty
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   work_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign q_full  = (count_ff == CntW'(Depth));
   assign q_empty = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CntW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- sv/escd_back.sv -----
// escd_back: walks queue head to output register, one result per cycle unless stalled
// depends on escd_pkg
module escd_back import escd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  work_type   head,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] out_byte,
   output logic [2:0] status,
   output logic       run_end
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] status_ff, status_in;
   logic       run_end_ff, run_end_in;

   logic [2:0] total;
   logic       last;
   logic       load;

   assign total = head.data.count + {2'b00, head.tail};
   assign last  = (idx_ff == (total - 3'd1));
   assign load  = !q_empty && (!valid_ff || pop);
   assign q_pop = load && last;

   always_comb begin
      idx_in     = idx_ff;
      valid_in   = valid_ff && !pop;
      byte_in    = byte_ff;
      status_in  = status_ff;
      run_end_in = run_end_ff;
      if (load) begin
         valid_in   = 1'b1;
         run_end_in = last;
         idx_in     = last ? 3'd0 : idx_ff + 3'd1;
         if (idx_ff < head.data.count) begin
            byte_in   = head.data.bytes[idx_ff[1:0]];
            status_in = StatusByte;
         end else begin
            byte_in   = '0;
            status_in = head.tail_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      status_ff  <= status_in;
      run_end_ff <= run_end_in;
   end

   assign empty    = !valid_ff;
   assign out_byte = byte_ff;
   assign status   = status_ff;
   assign run_end  = run_end_ff;

endmodule

// ----- sv/escape_sequence_decoder.sv -----
// escape_sequence_decoder: top level, parser front, work queue and result back end
// depends on escd_pkg, escd_front, escd_fifo, escd_back
//
//   channel   direction  transaction when     ports
//   request   in         push && !full        req_code_point, req_end_of_string
//   response  out        pop && !empty        rsp_out_byte, rsp_status, rsp_run_end
//
// the front takes one character per cycle while the work queue has room
// each character yields zero to five results; the back end sends one per cycle
// while the response side pops; each result is its own response transaction
// results of a request pass through the work queue, then the output register
// synchronous reset clears parser state, queue and the output valid flag
// a stalled response side fills the queue, then full holds off requests
module escape_sequence_decoder import escd_pkg::*; #(
   parameter int QueueDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [20:0] req_code_point,
   input  logic        req_end_of_string,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_status,
   output logic        rsp_run_end
);

   logic     q_full;
   logic     q_empty;
   logic     q_push;
   logic     q_pop;
   logic     accept;
   work_type wr_work;
   work_type head;

   assign full   = q_full;
   assign accept = push && !q_full;

   escd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .code_point    (req_code_point),
      .end_of_string (req_end_of_string),
      .work_push     (q_push),
      .work          (wr_work)
   );

   escd_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (wr_work),
      .rd_en   (q_pop),
      .rd_data (head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   escd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .out_byte (rsp_out_byte),
      .status   (rsp_status),
      .run_end  (rsp_run_end)
   );

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("work queue written while full");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("work queue read while empty");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !q_empty)
      else $error("work queue empty after a write");

   a_entry_not_blank: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (wr_work.tail || (wr_work.data.count != 3'd0)))
      else $error("work entry with no results");

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for escape_sequence_decoder
// depends on escd_pkg and escape_sequence_decoder; holds its own unescape predictor
// a directed table runs first, then random strings, with random idling on both queues
`timescale 1ns / 100ps

module tb_top import escd_pkg::*; ();

   localparam int RandomChars = 175;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 10;

   localparam logic [7:0] ByteBell      = 8'h07;
   localparam logic [7:0] ByteBackspace = 8'h08;
   localparam logic [7:0] ByteEscape    = 8'h1b;
   localparam logic [7:0] ByteNewline   = 8'h0a;
   localparam logic [7:0] ByteReturn    = 8'h0d;
   localparam logic [7:0] ByteTab       = 8'h09;
   localparam logic [7:0] ByteVtab      = 8'h0b;

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] status;
      logic       last;
   } decoded_type;

   typedef struct packed {
      logic [20:0] cp;
      logic        eos;
   } char_type;

   typedef struct {
      logic [20:0] cp;
      logic        eos;
      int          n;
      decoded_type r0;
      decoded_type r1;
   } walk_row_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [20:0] req_code_point;
   logic        req_end_of_string;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_status;
   logic        rsp_run_end;

   escape_sequence_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_code_point    (req_code_point),
      .req_end_of_string (req_end_of_string),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_status        (rsp_status),
      .rsp_run_end       (rsp_run_end)
   );

   // predictor state
   mode_type    esc_mode;
   kind_type    esc_kind;
   logic [3:0]  digits_left;
   logic [31:0] esc_value;
   logic        err_hold;

   decoded_type  step_out[$];
   decoded_type  pending_bytes[$];
   walk_row_type walk_rows[$];
   char_type     text_q[$];

   int          row_sel;
   logic        calm;
   int          mismatches;
   int          chars_taken;
   int          results_seen;
   int          strings_sent;
   int          error_results;
   int          stall_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_parser();
      esc_mode    = MODE_TEXT;
      esc_kind    = KIND_OCTAL;
      digits_left = '0;
      esc_value   = '0;
      err_hold    = 1'b0;
   endfunction

   function automatic void put_byte(input logic [7:0] data, input logic [2:0] status);
      decoded_type r;
      r.data   = data;
      r.status = status;
      r.last   = 1'b0;
      step_out.push_back(r);
   endfunction

   function automatic void put_utf8(input logic [31:0] v);
      if (v < 32'h80) begin
         put_byte(v[7:0], StatusByte);
      end else if (v < 32'h800) begin
         put_byte(8'hC0 | v[13:6], StatusByte);
         put_byte(8'h80 | v[5:0], StatusByte);
      end else if (v < 32'h10000) begin
         put_byte(8'hE0 | v[19:12], StatusByte);
         put_byte(8'h80 | v[11:6], StatusByte);
         put_byte(8'h80 | v[5:0], StatusByte);
      end else begin
         put_byte(8'hF0 | v[20:18], StatusByte);
         put_byte(8'h80 | v[17:12], StatusByte);
         put_byte(8'h80 | v[11:6], StatusByte);
         put_byte(8'h80 | v[5:0], StatusByte);
      end
   endfunction

   function automatic int digit_value(input logic [20:0] cp, input kind_type k);
      if (k == KIND_OCTAL) return (cp >= "0" && cp <= "7") ? int'(cp - "0") : -1;
      if (cp >= "0" && cp <= "9") return int'(cp - "0");
      if (cp >= "a" && cp <= "f") return int'(cp - "a") + 10;
      if (cp >= "A" && cp <= "F") return int'(cp - "A") + 10;
      return -1;
   endfunction

   function automatic void open_digits(input kind_type k, input logic [3:0] n,
                                       input logic [31:0] first);
      esc_mode    = MODE_DIGITS;
      esc_kind    = k;
      digits_left = n;
      esc_value   = first;
   endfunction

   // one character in, expected bytes and status results into step_out
   function automatic void unescape_step(input logic [20:0] cp, input logic eos);
      int   d;
      logic fault;
      step_out = {};
      fault = 1'b0;
      if (err_hold) begin
         if (eos) clear_parser();
         return;
      end
      case (esc_mode)
         MODE_TEXT: begin
            if (cp == "\\") esc_mode = MODE_ESCAPE;
            else put_utf8({11'd0, cp});
         end
         MODE_ESCAPE: begin
            esc_mode = MODE_TEXT;
            case (cp)
               "a":  put_byte(ByteBell, StatusByte);
               "b":  put_byte(ByteBackspace, StatusByte);
               "e":  put_byte(ByteEscape, StatusByte);
               "n":  put_byte(ByteNewline, StatusByte);
               "r":  put_byte(ByteReturn, StatusByte);
               "t":  put_byte(ByteTab, StatusByte);
               "v":  put_byte(ByteVtab, StatusByte);
               "\\": put_byte("\\", StatusByte);
               "'":  put_byte("'", StatusByte);
               "\"": put_byte("\"", StatusByte);
               "x":  open_digits(KIND_HEX, 4'd2, '0);
               "u":  open_digits(KIND_SHORT, 4'd4, '0);
               "U":  open_digits(KIND_LONG, 4'd8, '0);
               default: begin
                  if (cp >= "0" && cp <= "7") begin
                     open_digits(KIND_OCTAL, 4'd2, {11'd0, cp} - "0");
                  end else begin
                     put_byte(8'h00, StatusBadDigit);
                     fault = 1'b1;
                  end
               end
            endcase
         end
         default: begin
            if (cp != "_") begin
               d = digit_value(cp, esc_kind);
               if (d < 0) begin
                  put_byte(8'h00, StatusBadDigit);
                  fault = 1'b1;
               end else begin
                  if (esc_kind == KIND_OCTAL) esc_value = (esc_value << 3) | d;
                  else esc_value = (esc_value << 4) | d;
                  digits_left = digits_left - 4'd1;
                  if (digits_left == 4'd0) begin
                     esc_mode = MODE_TEXT;
                     if (esc_kind == KIND_OCTAL || esc_kind == KIND_HEX) begin
                        put_byte(esc_value[7:0], StatusByte);
                     end else if (esc_value < 32'h110000 &&
                                  (esc_value < 32'hD800 || esc_value > 32'hDFFF)) begin
                        put_utf8(esc_value);
                     end else begin
                        put_byte(8'h00, StatusBadCp);
                        fault = 1'b1;
                     end
                     esc_value = '0;
                  end
               end
            end
         end
      endcase
      if (fault) begin
         if (eos) clear_parser();
         else err_hold = 1'b1;
      end else if (eos) begin
         put_byte(8'h00, (esc_mode != MODE_TEXT) ? StatusTrunc : StatusDone);
         clear_parser();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      if (!reset) begin
         if (push && !full) begin
            unescape_step(req_code_point, req_end_of_string);
            if (row_sel >= 0 && walk_rows[row_sel].n > 0) begin
               step_out = {};
               step_out.push_back(walk_rows[row_sel].r0);
               if (walk_rows[row_sel].n > 1) step_out.push_back(walk_rows[row_sel].r1);
            end
            foreach (step_out[i]) pending_bytes.push_back(step_out[i]);
            chars_taken++;
         end
         if (pop && !empty) begin
            got.data   = rsp_out_byte;
            got.status = rsp_status;
            got.last   = rsp_run_end;
            results_seen++;
            if (rsp_status >= StatusTrunc) error_results++;
            if (pending_bytes.size() == 0) begin
               $display("%0t: unexpected transaction byte=%h status=%0d run_end=%b",
                        $time, got.data, got.status, got.last);
               mismatches++;
            end else begin
               want = pending_bytes.pop_front();
               if (want.data != got.data || want.status != got.status ||
                   want.last != got.last) begin
                  $display("%0t: mismatch expected byte=%h status=%0d run_end=%b",
                           $time, want.data, want.status, want.last);
                  $display("%0t:          actual   byte=%h status=%0d run_end=%b",
                           $time, got.data, got.status, got.last);
                  mismatches++;
               end
            end
         end
      end
      if ((push && !full) || (pop && !empty)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= StallLimit) begin
         $display("%0t: no transaction for %0d cycles", $time, StallLimit);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= calm || ($urandom_range(99) >= 17);
   end

   task automatic send_char(input logic [20:0] cp, input logic eos, input int row);
      while (!calm && $urandom_range(99) < 17) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push              <= 1'b1;
      req_code_point    <= cp;
      req_end_of_string <= eos;
      row_sel           <= row;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic add_row(input logic [20:0] cp, input logic eos, input int n,
                          input logic [7:0] b0, input logic [2:0] s0,
                          input logic [7:0] b1, input logic [2:0] s1);
      walk_row_type w;
      w.cp = cp;
      w.eos = eos;
      w.n = n;
      w.r0 = '{data: b0, status: s0, last: (n == 1)};
      w.r1 = '{data: b1, status: s1, last: 1'b1};
      walk_rows.push_back(w);
   endtask

   function automatic void put_char(input logic [20:0] cp);
      char_type c;
      c.cp  = cp;
      c.eos = 1'b0;
      text_q.push_back(c);
   endfunction

   function automatic logic [20:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 21'("0" + n);
      return 21'(($urandom_range(1) ? "a" : "A") + n - 4'd10);
   endfunction

   // digits in escape, underscores scattered among them
   function automatic void put_digits(input logic [31:0] v, input int n, input logic oct);
      for (int i = n - 1; i >= 0; i--) begin
         if ($urandom_range(99) < 8) put_char("_");
         if (oct) put_char(21'("0" + v[3*i +: 3]));
         else put_char(hex_char(v[4*i +: 4]));
      end
   endfunction

   function automatic void build_string();
      int          segs;
      logic [20:0] cp;
      logic [31:0] v;
      string       letters;
      letters = "abenrtv\\'\"";
      text_q = {};
      segs = $urandom_range(1, 6);
      for (int s = 0; s < segs; s++) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               case ($urandom_range(4))
                  0: cp = 21'($urandom_range(0, 127));
                  1: cp = 21'($urandom_range(128, 21'h7FF));
                  2: cp = 21'($urandom_range(21'h800, 21'hFFFF));
                  3: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                  default: cp = 21'($urandom_range(0, 21'h1FFFFF));
               endcase
               put_char((cp == "\\") ? 21'("A") : cp);
            end
            3: begin
               put_char("\\");
               put_char(21'(letters[$urandom_range(letters.len() - 1)]));
            end
            4: begin
               put_char("\\");
               put_char("x");
               put_digits($urandom_range(0, 255), 2, 1'b0);
            end
            5: begin
               put_char("\\");
               put_char(21'("0" + $urandom_range(0, 7)));
               for (int i = 0; i < 2; i++) begin
                  if ($urandom_range(99) < 8) put_char("_");
                  if ($urandom_range(99) < 6) put_char(21'("8" + $urandom_range(1)));
                  else put_char(21'("0" + $urandom_range(0, 7)));
               end
            end
            6: begin
               put_char("\\");
               put_char("u");
               case ($urandom_range(3))
                  0: v = 32'hD800 + $urandom_range(0, 32'h7FF);
                  1: v = $urandom_range(0, 127);
                  default: v = $urandom_range(0, 32'hFFFF);
               endcase
               put_digits(v, 4, 1'b0);
            end
            7: begin
               put_char("\\");
               put_char("U");
               case ($urandom_range(4))
                  0: v = $urandom();
                  1: v = $urandom_range(0, 1) ? 32'h110000 : 32'h10FFFF;
                  2: v = $urandom_range(0, 32'h7FF);
                  default: v = $urandom_range(0, 32'h10FFFF);
               endcase
               put_digits(v, 8, 1'b0);
            end
            8: begin
               put_char("\\");
               if ($urandom_range(1)) begin
                  put_char("x");
                  put_char($urandom_range(1) ? 21'("g") : 21'($urandom_range(0, 21'h1FFFFF)));
               end else begin
                  put_char(21'($urandom_range(0, 21'h1FFFFF)));
               end
            end
            default: put_char(21'($urandom_range(0, 21'h1FFFFF)));
         endcase
      end
      // sometimes cut the string off inside an escape
      if ($urandom_range(99) < 15) begin
         put_char("\\");
         if ($urandom_range(1)) begin
            put_char("U");
            put_digits($urandom_range(0, 32'hFFF), int'($urandom_range(0, 3)), 1'b0);
         end
      end
      text_q[text_q.size() - 1].eos = 1'b1;
   endfunction

   initial begin
      int sent;
      reset             = 1'b1;
      push              = 1'b0;
      req_code_point    = '0;
      req_end_of_string = 1'b0;
      row_sel           = -1;
      calm              = 1'b0;
      mismatches        = 0;
      chars_taken       = 0;
      results_seen      = 0;
      strings_sent      = 0;
      error_results     = 0;
      stall_count       = 0;
      clear_parser();

      // directed table: extremes, simple, hex, octal and short unicode escapes, each error, end of string cases
      add_row(21'h000000, 0, 1, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row(21'h1FFFFF, 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row(21'h0007FF, 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row(21'h00DFFF, 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("\\", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("n", 0, 1, ByteNewline, StatusByte, 8'h00, StatusByte);
      add_row("\\", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("x", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("f", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("_", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("F", 0, 1, 8'hFF, StatusByte, 8'h00, StatusByte);
      add_row("\\", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("7", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("7", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("7", 0, 1, 8'hFF, StatusByte, 8'h00, StatusByte);
      add_row("\\", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("u", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("D", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("8", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("0", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("0", 0, 1, 8'h00, StatusBadCp, 8'h00, StatusByte);
      add_row("z", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("q", 1, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("\\", 0, 0, 8'h00, StatusByte, 8'h00, StatusByte);
      add_row("_", 1, 1, 8'h00, StatusBadDigit, 8'h00, StatusByte);
      add_row("\\", 1, 1, 8'h00, StatusTrunc, 8'h00, StatusByte);
      add_row("A", 1, 2, "A", StatusByte, 8'h00, StatusDone);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (walk_rows[i]) send_char(walk_rows[i].cp, walk_rows[i].eos, i);
      strings_sent = 4;

      // random strings, with a stretch of steady traffic in the middle
      sent = 0;
      while (sent < RandomChars) begin
         build_string();
         foreach (text_q[i]) begin
            calm <= (sent >= 70 && sent < 130);
            send_char(text_q[i].cp, text_q[i].eos, -1);
            sent++;
         end
         strings_sent++;
      end
      push <= 1'b0;
      calm <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("characters: %0d in %0d strings, results checked: %0d",
               chars_taken, strings_sent, results_seen);
      $display("error or truncation results: %0d, mismatches: %0d",
               error_results, mismatches);
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/escd_pkg.sv
sv/escd_front.sv
sv/escd_fifo.sv
sv/escd_back.sv
sv/escape_sequence_decoder.sv
sim/tb_top.sv
